// ===== hdl/a64s_pkg.sv =====
// Shared constants, types and decode helpers for the A64-subset core.
package a64s_pkg;

    // Memory geometry: word count, word index width and byte address width.
    localparam int MEM_WORDS = 65536;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int BAW       = MEM_AW + 2;

    // Register file geometry; index 31 is the zero register.
    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = $clog2(RF_DEPTH);
    localparam logic [RF_AW-1:0] REG_ZR = 5'd31;

    // Special instruction words.
    localparam logic [31:0] HALT_WORD = 32'h8a00_0000;
    localparam logic [31:0] NOP_WORD  = 32'hd503_201f;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_MEM_WRITE = 2'd0,
        OP_EXEC      = 2'd1,
        OP_REG_READ  = 2'd2,
        OP_MEM_READ  = 2'd3
    } t_op;

    // Instruction group codes, bits 28 to 25.
    localparam logic [3:0] GRP_IMM_A = 4'd8;
    localparam logic [3:0] GRP_IMM_B = 4'd9;
    localparam logic [3:0] GRP_REG_A = 4'd5;
    localparam logic [3:0] GRP_REG_B = 4'd13;
    localparam logic [3:0] GRP_XFER  = 4'd12;
    localparam logic [3:0] GRP_BR_A  = 4'd10;
    localparam logic [3:0] GRP_BR_B  = 4'd11;

    // Immediate group sub-opcodes, bits 25 to 23.
    localparam logic [2:0] OPI_ADDSUB = 3'd2;
    localparam logic [2:0] OPI_MOVE   = 3'd5;

    // Wide move opc codes.
    localparam logic [1:0] MOV_N   = 2'd0;
    localparam logic [1:0] MOV_BAD = 2'd1;
    localparam logic [1:0] MOV_Z   = 2'd2;

    // Logical opc codes.
    localparam logic [1:0] LOG_ORR  = 2'd1;
    localparam logic [1:0] LOG_EOR  = 2'd2;
    localparam logic [1:0] LOG_ANDS = 2'd3;

    // Shift types.
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // Multiply group marker, bits 24 to 21.
    localparam logic [3:0] MUL_OP = 4'd8;

    // Register offset marker for loads and stores, bits 15 to 10.
    localparam logic [5:0] XFER_REGOFF = 6'h1a;

    // Branch kinds, bits 31 to 26.
    localparam logic [5:0] BR_IMM  = 6'h05;
    localparam logic [5:0] BR_REG  = 6'h35;
    localparam logic [5:0] BR_COND = 6'h15;

    // Supported condition codes.
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_GE = 4'ha;
    localparam logic [3:0] COND_LT = 4'hb;
    localparam logic [3:0] COND_GT = 4'hc;
    localparam logic [3:0] COND_LE = 4'hd;
    localparam logic [3:0] COND_AL = 4'he;

    // True when an instruction word lies outside the supported subset.
    function automatic logic ins_invalid(input logic [31:0] ins);
        logic [3:0] grp;
        logic [3:0] cnd;
        logic       bad;
        grp = ins[28:25];
        cnd = ins[3:0];
        if (grp == GRP_IMM_A || grp == GRP_IMM_B) begin
            if (ins[25:23] == OPI_ADDSUB) begin
                bad = 1'b0;
            end else if (ins[25:23] == OPI_MOVE) begin
                bad = (ins[30:29] == MOV_BAD) || (!ins[31] && ins[22]);
            end else begin
                bad = 1'b1;
            end
        end else if (grp == GRP_REG_A || grp == GRP_REG_B) begin
            if (ins[28]) begin
                bad = (ins[24:21] != MUL_OP);
            end else begin
                bad = (!ins[31] && ins[15]) || (ins[24] && (ins[21] || ins[23:22] == SH_ROR));
            end
        end else if (grp == GRP_XFER) begin
            bad = 1'b0;
        end else if (grp == GRP_BR_A || grp == GRP_BR_B) begin
            if (ins[31:26] == BR_IMM || ins[31:26] == BR_REG) begin
                bad = 1'b0;
            end else if (ins[31:26] == BR_COND) begin
                bad = !(cnd == COND_EQ || cnd == COND_NE || cnd == COND_GE || cnd == COND_LT ||
                        cnd == COND_GT || cnd == COND_LE || cnd == COND_AL);
            end else begin
                bad = 1'b1;
            end
        end else begin
            bad = 1'b1;
        end
        return bad;
    endfunction

    // Shifted register operand at 32 or 64 bits.
    function automatic logic [63:0] shift_operand(input logic [63:0] v, input logic [1:0] sh_type,
                                                  input logic [5:0] amt, input logic wide);
        logic [63:0] wm;
        logic [63:0] vm;
        logic [63:0] res;
        logic [6:0]  back;
        logic        sign;
        wm   = wide ? 64'hffff_ffff_ffff_ffff : 64'h0000_0000_ffff_ffff;
        vm   = v & wm;
        sign = wide ? vm[63] : vm[31];
        back = (wide ? 7'd64 : 7'd32) - {1'b0, amt};
        unique case (sh_type)
            SH_LSL: res = (vm << amt) & wm;
            SH_LSR: res = vm >> amt;
            SH_ASR: res = sign ? ((vm >> amt) | (~(wm >> amt) & wm)) : (vm >> amt);
            SH_ROR: res = (amt == 6'd0) ? vm : (((vm >> amt) | (vm << back)) & wm);
        endcase
        return res;
    endfunction

endpackage

// ===== hdl/a64s_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module a64s_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/a64_subset_core.sv =====
// A64-subset core: multicycle sequencer, register file RAM, memory RAM and shared datapath.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------------
//  request | in        | i_valid / o_stall  | i_opcode, i_word_address, i_write_data
//  result  | out       | o_valid / i_stall  | o_read_data, o_program_counter, o_flags,
//          |           |                    | o_halted, o_invalid
//
// Memory writes pass through IDLE and FIN; memory and register reads through IDLE, HRD and FIN.
// An executed instruction goes through a fetch of one or two words through the single memory read
// port, three operand reads from the register file port, an EX1 step and, for ALU instructions,
// an EX2 step, the MUL steps and a MAC step for a multiply on the shared 32x32 multiplier, and
// one read (plus write for stores) per touched word for loads and stores, up to three words.
// After reset the memory is cleared one word a cycle, and no request is taken until it is done. A
// finished result waits in an output register, so the next request is taken while the result side stalls.
module a64_subset_core
    import a64s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_word_address,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_read_data,
    output logic [17:0] o_program_counter,
    output logic [3:0]  o_flags,
    output logic        o_halted,
    output logic        o_invalid
);

    typedef enum logic [16:0] {
        S_CLR  = 17'b0_0000_0000_0000_0001,
        S_IDLE = 17'b0_0000_0000_0000_0010,
        S_HRD  = 17'b0_0000_0000_0000_0100,
        S_MRD  = 17'b0_0000_0000_0000_1000,
        S_MDAT = 17'b0_0000_0000_0001_0000,
        S_DEC  = 17'b0_0000_0000_0010_0000,
        S_RA   = 17'b0_0000_0000_0100_0000,
        S_RB   = 17'b0_0000_0000_1000_0000,
        S_RC   = 17'b0_0000_0001_0000_0000,
        S_RD   = 17'b0_0000_0010_0000_0000,
        S_EX1  = 17'b0_0000_0100_0000_0000,
        S_EX2  = 17'b0_0000_1000_0000_0000,
        S_MUL  = 17'b0_0001_0000_0000_0000,
        S_MAC  = 17'b0_0010_0000_0000_0000,
        S_XW   = 17'b0_0100_0000_0000_0000,
        S_XL   = 17'b0_1000_0000_0000_0000,
        S_FIN  = 17'b1_0000_0000_0000_0000
    } t_state;

    // Control state.
    t_state            r_state;
    logic [MEM_AW-1:0] r_clr;
    logic [17:0]       r_pc;
    logic [3:0]        r_flags;
    logic              r_halt;
    logic              r_err;
    logic [31:0]       r_rf_vld;
    logic              r_ovld;
    logic [1:0]        r_mk;

    // Datapath registers.
    logic [31:0]       r_ins;
    logic [63:0]       r_a;
    logic [63:0]       r_b;
    logic [63:0]       r_c;
    logic              r_rz;
    logic              r_hreg;
    logic [BAW-1:0]    r_maddr;
    logic              r_n8;
    logic              r_mst;
    logic              r_fetch;
    logic [95:0]       r_buf;
    logic              r_ld;
    logic              r_dowb;
    logic [63:0]       r_wb;
    logic [63:0]       r_opb;
    logic [63:0]       r_mp;
    logic [63:0]       r_prod;
    logic [63:0]       r_rdv;
    logic [63:0]       r_odata;
    logic [17:0]       r_opc;
    logic [3:0]        r_oflags;
    logic              r_ohalt;
    logic              r_oerr;

    // Handshake.
    logic in_acc;
    logic out_acc;
    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovld && !i_stall;

    // Word index of the request.
    logic [31:0]       wa32;
    logic [MEM_AW-1:0] wa_m;
    assign wa32 = {16'b0, i_word_address};
    assign wa_m = wa32[MEM_AW-1:0];

    // Memory access engine: word walk, byte extraction and store merge.
    logic [1:0]        lane;
    logic [MEM_AW-1:0] widx_k;
    logic [3:0]        lsum;
    logic [1:0]        last_k;
    logic [95:0]       ext;
    logic [63:0]       load_val;
    logic [95:0]       sdata;
    logic [11:0]       bmask;
    logic [3:0]        m4;
    logic [31:0]       sword;
    logic [31:0]       mword;
    logic [31:0]       m_rdata;

    assign lane     = r_maddr[1:0];
    assign widx_k   = r_maddr[BAW-1:2] + {{(MEM_AW-2){1'b0}}, r_mk};
    assign lsum     = {2'b0, lane} + (r_n8 ? 4'd7 : 4'd3);
    assign last_k   = lsum[3:2];
    assign ext      = r_buf >> {lane, 3'b000};
    assign load_val = r_n8 ? ext[63:0] : {32'b0, ext[31:0]};
    assign sdata    = {32'b0, r_c} << {lane, 3'b000};
    assign bmask    = (r_n8 ? 12'h0ff : 12'h00f) << lane;
    assign m4       = bmask[{r_mk, 2'b00} +: 4];
    assign sword    = sdata[{r_mk, 5'b00000} +: 32];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mword[8*i +: 8] = m4[i] ? sword[8*i +: 8] : m_rdata[8*i +: 8];
        end
    end

    // Instruction fields and classes.
    logic [3:0]  grp;
    logic        wide;
    logic [63:0] wm;
    logic        is_imm;
    logic        is_move;
    logic        is_reg;
    logic        is_mul;
    logic        is_xfer;
    logic [4:0]  idx1;
    logic [4:0]  idx2;
    logic [4:0]  idx3;

    assign grp     = r_ins[28:25];
    assign wide    = r_ins[31];
    assign wm      = wide ? 64'hffff_ffff_ffff_ffff : 64'h0000_0000_ffff_ffff;
    assign is_imm  = (grp == GRP_IMM_A) || (grp == GRP_IMM_B);
    assign is_move = is_imm && (r_ins[25:23] == OPI_MOVE);
    assign is_reg  = (grp == GRP_REG_A) || (grp == GRP_REG_B);
    assign is_mul  = is_reg && r_ins[28];
    assign is_xfer = (grp == GRP_XFER);
    assign idx1    = r_ins[9:5];
    assign idx2    = r_ins[20:16];
    assign idx3    = is_mul ? r_ins[14:10] : r_ins[4:0];

    // Wide move result.
    logic [5:0]  mv_sh;
    logic [63:0] mv_op;
    logic [63:0] mv_res;
    assign mv_sh = {r_ins[22:21], 4'b0000};
    assign mv_op = {48'b0, r_ins[20:5]} << mv_sh;

    always_comb begin
        case (r_ins[30:29])
            MOV_N:   mv_res = ~mv_op & wm;
            MOV_Z:   mv_res = mv_op;
            default: mv_res = ((r_c & ~(64'h0000_0000_0000_ffff << mv_sh)) | mv_op) & wm;
        endcase
    end

    // Second operand for the ALU cycle.
    logic [63:0] imm_add;
    logic [63:0] shifted;
    assign imm_add = r_ins[22] ? {40'b0, r_ins[21:10], 12'b0} : {52'b0, r_ins[21:10]};
    assign shifted = shift_operand(r_b, r_ins[23:22], r_ins[15:10], wide);

    // Load and store address: one 64-bit add.
    logic        x_lit;
    logic        x_post;
    logic [63:0] x_left;
    logic [63:0] x_right;
    logic [63:0] x_sum;
    logic [63:0] x_addr;
    logic [63:0] pc64;
    assign pc64   = {46'b0, r_pc};
    assign x_lit  = !r_ins[31];
    assign x_post = r_ins[31] && !r_ins[24] && (r_ins[15:10] != XFER_REGOFF) && !r_ins[11];

    always_comb begin
        x_left = x_lit ? pc64 : r_a;
        priority if (x_lit) begin
            x_right = {{43{r_ins[23]}}, r_ins[23:5], 2'b00};
        end else if (r_ins[24]) begin
            x_right = r_ins[30] ? {49'b0, r_ins[21:10], 3'b000} : {50'b0, r_ins[21:10], 2'b00};
        end else if (r_ins[15:10] == XFER_REGOFF) begin
            x_right = r_b;
        end else begin
            x_right = {{55{r_ins[20]}}, r_ins[20:12]};
        end
    end

    assign x_sum  = x_left + x_right;
    assign x_addr = x_post ? r_a : x_sum;

    // Branch target.
    logic        take;
    logic [17:0] br_pc;
    logic        fn;
    logic        fz;
    logic        fv;
    assign fn = r_flags[3];
    assign fz = r_flags[2];
    assign fv = r_flags[0];

    always_comb begin
        case (r_ins[3:0])
            COND_EQ: take = fz;
            COND_NE: take = !fz;
            COND_GE: take = (fn == fv);
            COND_LT: take = (fn != fv);
            COND_GT: take = !fz && (fn == fv);
            COND_LE: take = !(!fz && (fn == fv));
            default: take = 1'b1;
        endcase
    end

    always_comb begin
        priority if (r_ins[31:26] == BR_IMM) begin
            br_pc = r_pc + {r_ins[15:0], 2'b00};
        end else if (r_ins[31:26] == BR_REG) begin
            br_pc = r_a[17:0];
        end else if (take) begin
            br_pc = r_pc + {r_ins[20:5], 2'b00};
        end else begin
            br_pc = r_pc + 18'd4;
        end
    end

    // Add/sub and logical unit.
    logic [63:0] al_a;
    logic [63:0] al_b;
    logic [63:0] al_bb;
    logic [64:0] al_s;
    logic [63:0] al_sum;
    logic        al_c;
    logic [63:0] al_v;
    logic        al_arith;
    logic [63:0] lg_b;
    logic [63:0] lg_res;
    logic [63:0] al_res;
    logic [3:0]  al_flags;
    logic        al_setf;

    assign al_a     = r_a & wm;
    assign al_b     = r_opb;
    assign al_bb    = r_ins[30] ? (~al_b & wm) : al_b;
    assign al_s     = {1'b0, al_a} + {1'b0, al_bb} + {64'b0, r_ins[30]};
    assign al_sum   = wide ? al_s[63:0] : {32'b0, al_s[31:0]};
    assign al_c     = wide ? al_s[64] : al_s[32];
    assign al_v     = (al_a ^ al_sum) & (al_bb ^ al_sum);
    assign al_arith = is_imm || r_ins[24];
    assign lg_b     = r_ins[21] ? (~al_b & wm) : al_b;

    always_comb begin
        case (r_ins[30:29])
            LOG_ORR: lg_res = al_a | lg_b;
            LOG_EOR: lg_res = al_a ^ lg_b;
            default: lg_res = al_a & lg_b;
        endcase
    end

    always_comb begin
        al_res   = al_arith ? al_sum : lg_res;
        al_setf  = al_arith ? r_ins[29] : (r_ins[30:29] == LOG_ANDS);
        if (al_arith) begin
            al_flags = {wide ? al_sum[63] : al_sum[31], al_sum == 64'b0, al_c,
                        wide ? al_v[63] : al_v[31]};
        end else begin
            al_flags = {wide ? lg_res[63] : lg_res[31], lg_res == 64'b0, 2'b00};
        end
    end

    // Shared 32x32 multiplier for the partial products.
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;
    logic [63:0] mac_acc;
    logic [63:0] mac_res;
    assign mul_x   = (r_mk == 2'd2) ? (wide ? r_a[63:32] : 32'b0) : r_a[31:0];
    assign mul_y   = (r_mk == 2'd1) ? (wide ? r_b[63:32] : 32'b0) : r_b[31:0];
    assign mul_p   = mul_x * mul_y;
    assign mac_acc = r_c & wm;
    assign mac_res = (r_ins[15] ? (mac_acc - r_prod) : (mac_acc + r_prod)) & wm;

    // Main memory port selection.
    logic              m_we;
    logic [MEM_AW-1:0] m_waddr;
    logic [31:0]       m_wdata;
    logic [MEM_AW-1:0] m_raddr;

    always_comb begin
        m_we    = 1'b0;
        m_waddr = widx_k;
        m_wdata = mword;
        m_raddr = widx_k;
        if (r_state == S_CLR) begin
            m_we    = 1'b1;
            m_waddr = r_clr;
            m_wdata = 32'b0;
        end else if (r_state == S_IDLE) begin
            m_we    = in_acc && (i_opcode == OP_MEM_WRITE);
            m_waddr = wa_m;
            m_wdata = i_write_data;
            m_raddr = wa_m;
        end else if (r_state == S_MDAT) begin
            m_we    = r_mst;
        end
    end

    a64s_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    // Register file port selection.
    logic [RF_AW-1:0] rf_raddr;
    logic             rf_rzero;
    logic [63:0]      rf_rdata;
    logic [63:0]      rf_val;
    logic             rf_wreq;
    logic             rf_we;
    logic [RF_AW-1:0] rf_waddr;
    logic [63:0]      rf_wdata;

    always_comb begin
        rf_raddr = idx1;
        rf_rzero = 1'b0;
        if (r_state == S_IDLE) begin
            rf_raddr = i_word_address[4:0];
            rf_rzero = (i_word_address[15:5] != 11'b0);
        end else if (r_state == S_RB) begin
            rf_raddr = idx2;
        end else if (r_state == S_RC) begin
            rf_raddr = idx3;
        end
        rf_rzero = rf_rzero || !r_rf_vld[rf_raddr];
    end

    assign rf_val = r_rz ? 64'b0 : rf_rdata;

    always_comb begin
        rf_wreq  = 1'b0;
        rf_waddr = r_ins[4:0];
        rf_wdata = al_res;
        if (r_state == S_EX1) begin
            rf_wreq  = is_move;
            rf_wdata = mv_res;
        end else if (r_state == S_EX2) begin
            rf_wreq  = 1'b1;
        end else if (r_state == S_MAC) begin
            rf_wreq  = 1'b1;
            rf_wdata = mac_res;
        end else if (r_state == S_XW) begin
            rf_wreq  = r_dowb;
            rf_waddr = idx1;
            rf_wdata = r_wb;
        end else if (r_state == S_XL) begin
            rf_wreq  = r_ld;
            rf_wdata = load_val;
        end
    end

    assign rf_we = rf_wreq && (rf_waddr != REG_ZR);

    a64s_ram #(
        .WIDTH (64),
        .DEPTH (RF_DEPTH)
    ) u_rf (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata)
    );

    // Sequencer and architectural state.
    always_ff @(posedge i_clk) begin
        r_rz <= rf_rzero;
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_pc     <= 18'd0;
            r_flags  <= 4'b0100;
            r_halt   <= 1'b0;
            r_err    <= 1'b0;
            r_rf_vld <= 32'b0;
            r_ovld   <= 1'b0;
            r_mk     <= 2'd0;
        end else begin
            if (out_acc) begin
                r_ovld <= 1'b0;
            end
            if (rf_we) begin
                r_rf_vld[rf_waddr] <= 1'b1;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == {MEM_AW{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_rdv <= 64'b0;
                        unique case (i_opcode)
                            OP_MEM_WRITE: r_state <= S_FIN;
                            OP_EXEC: begin
                                if (r_halt) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_maddr <= pc64[BAW-1:0];
                                    r_n8    <= 1'b0;
                                    r_mst   <= 1'b0;
                                    r_fetch <= 1'b1;
                                    r_mk    <= 2'd0;
                                    r_state <= S_MRD;
                                end
                            end
                            OP_REG_READ: begin
                                r_hreg  <= 1'b1;
                                r_state <= S_HRD;
                            end
                            OP_MEM_READ: begin
                                r_hreg  <= 1'b0;
                                r_state <= S_HRD;
                            end
                        endcase
                    end
                end
                S_HRD: begin
                    r_rdv   <= r_hreg ? rf_val : {32'b0, m_rdata};
                    r_state <= S_FIN;
                end
                S_MRD: begin
                    r_state <= S_MDAT;
                end
                S_MDAT: begin
                    r_buf[{r_mk, 5'b00000} +: 32] <= m_rdata;
                    if (r_mk == last_k) begin
                        r_state <= r_fetch ? S_DEC : S_XW;
                    end else begin
                        r_mk    <= r_mk + 2'd1;
                        r_state <= S_MRD;
                    end
                end
                S_DEC: begin
                    r_ins <= ext[31:0];
                    if (ext[31:0] == HALT_WORD) begin
                        r_halt  <= 1'b1;
                        r_state <= S_FIN;
                    end else if (ext[31:0] == NOP_WORD) begin
                        r_pc    <= r_pc + 18'd4;
                        r_state <= S_FIN;
                    end else if (ins_invalid(ext[31:0])) begin
                        r_halt  <= 1'b1;
                        r_err   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_RA;
                    end
                end
                S_RA: r_state <= S_RB;
                S_RB: begin
                    r_a     <= rf_val;
                    r_state <= S_RC;
                end
                S_RC: begin
                    r_b     <= rf_val;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_c     <= rf_val;
                    r_mk    <= 2'd0;
                    r_state <= S_EX1;
                end
                S_EX1: begin
                    r_opb <= is_imm ? imm_add : shifted;
                    if (is_move) begin
                        r_pc    <= r_pc + 18'd4;
                        r_state <= S_FIN;
                    end else if (is_mul) begin
                        r_state <= S_MUL;
                    end else if (is_xfer) begin
                        r_maddr <= x_addr[BAW-1:0];
                        r_n8    <= r_ins[30];
                        r_ld    <= x_lit || r_ins[22];
                        r_mst   <= !(x_lit || r_ins[22]);
                        r_dowb  <= r_ins[31] && !r_ins[24] && (r_ins[15:10] != XFER_REGOFF);
                        r_wb    <= x_sum;
                        r_fetch <= 1'b0;
                        r_mk    <= 2'd0;
                        r_state <= S_MRD;
                    end else if (is_reg || is_imm) begin
                        r_state <= S_EX2;
                    end else begin
                        r_pc    <= br_pc;
                        r_state <= S_FIN;
                    end
                end
                S_EX2: begin
                    if (al_setf) begin
                        r_flags <= al_flags;
                    end
                    r_pc    <= r_pc + 18'd4;
                    r_state <= S_FIN;
                end
                S_MUL: begin
                    r_mp <= mul_p;
                    r_mk <= r_mk + 2'd1;
                    if (r_mk == 2'd1) begin
                        r_prod <= r_mp;
                    end else if (r_mk != 2'd0) begin
                        r_prod <= r_prod + {r_mp[31:0], 32'b0};
                    end
                    if (r_mk == 2'd3) begin
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_pc    <= r_pc + 18'd4;
                    r_state <= S_FIN;
                end
                S_XW: r_state <= S_XL;
                S_XL: begin
                    r_pc    <= r_pc + 18'd4;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovld || !i_stall) begin
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result register, loaded when the sequencer finishes an item.
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_ovld || !i_stall)) begin
            r_odata  <= r_rdv;
            r_opc    <= r_pc;
            r_oflags <= r_flags;
            r_ohalt  <= r_halt;
            r_oerr   <= r_err;
        end
    end

    assign o_valid           = r_ovld;
    assign o_read_data       = r_odata;
    assign o_program_counter = r_opc;
    assign o_flags           = r_oflags;
    assign o_halted          = r_ohalt;
    assign o_invalid         = r_oerr;

    // An error stop always halts the core.
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> r_halt)
        else $error("error flag set without halt");

    // The zero register never becomes a valid register file entry.
    a_zr_never_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rf_vld[31])
        else $error("zero register marked valid");

    // The word walk never passes the last word of an access.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MDAT) |-> (r_mk <= last_k))
        else $error("memory walk beyond last word");

    // Executing while halted leaves PC and flags alone.
    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_opcode == OP_EXEC && r_halt) |=> ($stable(r_pc) && $stable(r_flags)))
        else $error("halted core changed state");

    // A finished item whose result slot is free is presented on the next cycle.
    a_fin_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_ovld) |=> r_ovld)
        else $error("finished result not presented");

endmodule
